>>> design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed across reset");

`endif

>>> design/sird_pkg.sv
// Shared constants, types and state encoding for the radix text converter.
// No dependencies; imported by every module of the block but sird_ram.
package sird_pkg;

  // Stream and register geometry
  localparam int NUMBER_W       = 32;
  localparam int CHAR_W         = 8;
  localparam int COUNT_W        = 6;
  localparam int NUM_WORDS      = 7;
  localparam int SYMS_PER_WORD  = 8;
  localparam int NUM_SYMBOLS    = NUM_WORDS * SYMS_PER_WORD;
  localparam int SYM_SEL_W      = $clog2(NUM_SYMBOLS);
  localparam int APB_DATA_W     = 64;
  localparam int REG_IDX_W      = 3;
  localparam int APB_ADDR_W     = REG_IDX_W + 3;
  localparam int STACK_DEPTH    = 32;
  localparam int STACK_AW       = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W      = $clog2(NUMBER_W);
  localparam int DEF_MAX_SYMBOLS = 56;

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORD_BASE    = 3'd1;

  // Reset values
  localparam logic [COUNT_W-1:0]    RST_SYMBOL_COUNT = 6'd10;
  localparam logic [APB_DATA_W-1:0] RST_WORD0 = 64'h3736_3534_3332_3130;
  localparam logic [APB_DATA_W-1:0] RST_WORD1 = 64'h0000_0000_0000_3938;

  // Character codes and limits
  localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0]  DEL_CHAR   = 8'd127;
  localparam logic [CHAR_W-1:0]  NULL_CHAR  = 8'd0;
  localparam logic [COUNT_W-1:0] MIN_RADIX  = 6'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_FAIL
  } state_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;
    logic start;
  } div_ctl_t;

endpackage

>>> design/signed_integer_to_radix_digits.sv
// Signed 32-bit number to text in a programmable radix, most significant
// character first, one character per output transaction with tlast on the
// final one. An item is accepted, then the alphabet is checked one symbol
// per cycle, each digit beyond the first takes a division (the bit-serial
// divider yields one quotient bit per cycle), the digit loop closes and the
// sign is placed, and each character is read back from the digit stack RAM
// and emitted, waiting on output stalls. An invalid alphabet gives a single
// transaction with tuser low. Depends on sird_pkg, sird_regs, sird_div and
// sird_ram.
module signed_integer_to_radix_digits #(
  parameter int MAX_SYMBOLS = sird_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sird_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sird_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sird_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sird_pkg::NUMBER_W-1:0]    s_tdata,   // [31:0] number
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sird_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] out_char
  output logic                             m_tlast,
  output logic                             m_tuser    // [0] base_ok
);

  import sird_pkg::*;

  localparam int DIG_W = $clog2(MAX_SYMBOLS);
  localparam int RAD_W = $clog2(MAX_SYMBOLS + 1);

  state_t state, state_next;

  logic [COUNT_W-1:0]   symbol_count;
  logic [CHAR_W-1:0]    sym;
  logic [DIG_W-1:0]     sym_idx;
  logic [DIG_W-1:0]     chk_idx;
  logic [2**CHAR_W-1:0] seen;
  logic                 neg;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W-1:0]   rd_k;

  logic                 accept;
  logic                 radix_ok;
  logic [RAD_W-1:0]     radix;
  logic                 sym_bad;
  logic                 chk_end;
  logic                 out_free;

  div_ctl_t             div_ctl;
  logic                 div_done;
  logic [NUMBER_W-1:0]  div_quo;
  logic [DIG_W-1:0]     div_rem;
  logic [NUMBER_W-1:0]  mag_in;
  logic                 more_digits;

  logic                 ram_we;
  logic [DIG_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [DIG_W-1:0]     ram_rdata;
  logic [COUNT_W-1:0]   rd_k_dec;

  logic                 out_load;
  logic [CHAR_W-1:0]    out_char_next;
  logic                 out_last_next;
  logic                 out_ok_next;

  // Register bank
  sird_regs #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sym_idx      (sym_idx),
    .sym          (sym),
    .symbol_count (symbol_count)
  );

  // Divider, also holding the running magnitude
  sird_div #(.RAD_W(RAD_W), .DIG_W(DIG_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .load_val (mag_in),
    .radix    (radix),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Digit stack, least significant digit at address 0
  sird_ram #(.WIDTH(DIG_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[STACK_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_k_dec[STACK_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Datapath decodes
  assign accept   = s_tvalid & s_tready;
  assign mag_in   = s_tdata[NUMBER_W-1] ? (~s_tdata + 1'b1) : s_tdata;
  assign radix_ok = (symbol_count >= MIN_RADIX) &&
                    (symbol_count <= COUNT_W'(MAX_SYMBOLS));
  assign radix    = RAD_W'(symbol_count);
  assign sym_bad  = (sym <= SPACE_CHAR) || (sym == DEL_CHAR) || seen[sym];
  assign chk_end  = COUNT_W'(chk_idx) == (symbol_count - 1'b1);
  assign more_digits = (div_quo >= NUMBER_W'(radix)) &&
                       (total != COUNT_W'(STACK_DEPTH - 1));
  assign sym_idx  = (state == ST_EMIT) ? ram_rdata : chk_idx;
  assign ram_wdata = (state == ST_DIV) ? div_rem : div_quo[DIG_W-1:0];
  assign rd_k_dec = rd_k - 1'b1;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!radix_ok || sym_bad) state_next = ST_FAIL;
        else if (chk_end) state_next = ST_TEST;
      end
      ST_TEST: begin
        state_next = more_digits ? ST_DIV : ST_SIGN;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_TEST;
      end
      ST_SIGN: begin
        if (!neg || out_free) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = (rd_k == '0) ? ST_IDLE : ST_READ;
      end
      ST_FAIL: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control strobes and output payload
  always_comb begin
    s_tready      = 1'b0;
    div_ctl.load  = 1'b0;
    div_ctl.start = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    out_char_next = NULL_CHAR;
    out_last_next = 1'b1;
    out_ok_next   = 1'b1;
    case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        div_ctl.load = s_tvalid;
      end
      ST_TEST: begin
        div_ctl.start = more_digits;
        ram_we        = !more_digits;
      end
      ST_DIV: begin
        ram_we = div_done;
      end
      ST_SIGN: begin
        out_load      = neg && out_free;
        out_char_next = MINUS_CHAR;
        out_last_next = 1'b0;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_EMIT: begin
        out_load      = out_free;
        out_char_next = sym;
        out_last_next = (rd_k == '0);
      end
      ST_FAIL: begin
        out_load    = out_free;
        out_ok_next = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Alphabet check bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      neg     <= s_tdata[NUMBER_W-1];
      chk_idx <= '0;
      seen    <= '0;
    end else if (state == ST_CHECK) begin
      chk_idx   <= chk_idx + 1'b1;
      seen[sym] <= 1'b1;
    end
  end

  // Digit count and read-back pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      total <= '0;
    end else if (ram_we) begin
      total <= total + 1'b1;
    end
    if (state == ST_SIGN) begin
      rd_k <= total;
    end else if (ram_re) begin
      rd_k <= rd_k_dec;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_char_next;
      m_tlast <= out_last_next;
      m_tuser <= out_ok_next;
    end
  end

endmodule

>>> design/sird_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the digit stack of the converter.
module sird_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/sird_regs.sv
// APB register bank: radix and symbol alphabet, plus the symbol lookup port.
// Depends on sird_pkg.
module sird_regs #(
  parameter int MAX_SYMBOLS = sird_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sird_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sird_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sird_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic [$clog2(MAX_SYMBOLS)-1:0]    sym_idx,
  output logic [sird_pkg::CHAR_W-1:0]       sym,
  output logic [sird_pkg::COUNT_W-1:0]      symbol_count
);

  import sird_pkg::*;

  logic [APB_DATA_W-1:0] words [NUM_WORDS];
  logic [CHAR_W-1:0]     sym_tab [NUM_SYMBOLS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [REG_IDX_W-1:0]  word_sel;
  logic [SYM_SEL_W-1:0]  sel;
  logic                  wr;

  assign pready   = 1'b1;
  assign wr       = psel & penable & pwrite & pready;
  assign reg_idx  = paddr[APB_ADDR_W-1:3];
  assign word_sel = reg_idx - REG_WORD_BASE;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= RST_SYMBOL_COUNT;
      for (int w = 0; w < NUM_WORDS; w++) begin
        words[w] <= (w == 0) ? RST_WORD0 : ((w == 1) ? RST_WORD1 : '0);
      end
    end else if (wr) begin
      if (reg_idx == REG_SYMBOL_COUNT) begin
        symbol_count <= pwdata[COUNT_W-1:0];
      end else begin
        words[word_sel] <= pwdata;
      end
    end
  end

  // Register reads
  always_comb begin
    if (reg_idx == REG_SYMBOL_COUNT) begin
      prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, symbol_count};
    end else begin
      prdata = words[word_sel];
    end
  end

  // Alphabet as a byte table; one lookup port shared by check and emit
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int b = 0; b < SYMS_PER_WORD; b++) begin
        sym_tab[w*SYMS_PER_WORD + b] = words[w][CHAR_W*b +: CHAR_W];
      end
    end
  end

  assign sel = SYM_SEL_W'(sym_idx);
  assign sym = (32'(sel) < NUM_SYMBOLS) ? sym_tab[sel] : NULL_CHAR;

endmodule

>>> design/sird_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
// Depends on sird_pkg. Holds the running magnitude between divisions.
module sird_div #(
  parameter int RAD_W = 6,
  parameter int DIG_W = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sird_pkg::div_ctl_t              ctl,
  input  logic [sird_pkg::NUMBER_W-1:0]   load_val,
  input  logic [RAD_W-1:0]                radix,
  output logic                            done,
  output logic [sird_pkg::NUMBER_W-1:0]   quo,
  output logic [DIG_W-1:0]                rem
);

  import sird_pkg::*;

  logic [NUMBER_W-1:0]  q;
  logic [RAD_W:0]       r;
  logic [RAD_W:0]       r_shift;
  logic [RAD_W:0]       r_next;
  logic                 fits;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign r_shift = {r[RAD_W-1:0], q[NUMBER_W-1]};
  assign fits    = r_shift >= {1'b0, radix};
  assign r_next  = fits ? (r_shift - {1'b0, radix}) : r_shift;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !ctl.start && (cnt == DIV_CNT_W'(NUMBER_W - 1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUMBER_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_val;
    end else if (ctl.start) begin
      r <= '0;
    end else if (busy) begin
      q <= {q[NUMBER_W-2:0], fits};
      r <= r_next;
    end
  end

  assign quo = q;
  assign rem = r[DIG_W-1:0];

endmodule

>>> design/sird_checker.sv
// Port-level checks for the radix text converter, bound to the top level.
// Depends on sird_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sird_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [sird_pkg::CHAR_W-1:0] m_tdata,
  input logic                        m_tlast,
  input logic                        m_tuser
);

  import sird_pkg::*;

  // A stalled output transaction holds its payload
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

  // A rejected alphabet gives a lone null character
  `CHK_IMPL(a_fail_form, clk, rst, m_tvalid && !m_tuser, m_tlast && (m_tdata == NULL_CHAR))

  // Converted text never carries a control, space or delete code
  `CHK_IMPL(a_char_range, clk, rst, m_tvalid && m_tuser, (m_tdata > SPACE_CHAR) && (m_tdata != DEL_CHAR))

  // One number at a time: busy right after taking one
  `CHK_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // Reset leaves the block empty and ready
  `CHK_NEXT_ALWAYS(a_reset_state, clk, rst, !m_tvalid && s_tready)

endmodule

bind signed_integer_to_radix_digits sird_checker u_sird_checker (.*);
